// ===== hw/rtl/fcsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_pkg
// Widths, packing constants and shared types for the filled circle span
// generator and its square root unit.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int COORD_W     = 15;  // input centre coordinates
    localparam int OUT_COORD_W = 16;  // span column and row outputs
    localparam int RAD_W       = 6;   // radius and row offset
    localparam int COLOR_W     = 32;  // four 8-bit components
    localparam int WIDTH_W     = 7;   // span length, twice the half width

    // Square root datapath: operand below 2^12, running root and trial bit
    // one bit wider so that the first trial bit fits.
    localparam int SQ_W   = 12;
    localparam int ACC_W  = 13;
    localparam int ROOT_W = 6;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    // Status of the square root unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } root_status_t;

endpackage

// ===== hw/rtl/fcsg_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_isqrt
// Bit-serial integer square root: one trial subtraction per cycle, two
// operand bits retired per step, floor(sqrt(operand)) after seven steps.
// ----------------------------------------------------------------------------
module fcsg_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fcsg_pkg::SQ_W-1:0]   operand,
    output fcsg_pkg::root_status_t      status,
    output logic [fcsg_pkg::ROOT_W-1:0] root
);
    import fcsg_pkg::*;

    localparam logic [ACC_W-1:0] BIT_INIT = ACC_W'(1) << (ACC_W - 1);

    logic [SQ_W-1:0]  rem_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [ACC_W:0]   trial;
    logic             fits;
    logic [SQ_W-1:0]  rem_next;
    logic [ACC_W-1:0] acc_next;

    // The trial value is root plus the current bit; it is taken away from
    // the remainder only when it fits.
    always_comb begin
        trial    = {1'b0, acc_reg} + {1'b0, bit_reg};
        fits     = {{(ACC_W + 1 - SQ_W){1'b0}}, rem_reg} >= trial;
        rem_next = fits ? (rem_reg - trial[SQ_W-1:0]) : rem_reg;
        acc_next = fits ? ((acc_reg >> 1) + bit_reg) : (acc_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= operand;
            acc_reg <= '0;
            bit_reg <= BIT_INIT;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = acc_reg[ROOT_W-1:0];

endmodule

// ===== hw/rtl/filled_circle_span_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Turns one filled circle command into one horizontal span per row offset,
// from the middle row outwards, each span mirrored above and below.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Ports                          Carries
// s_        in         s_tvalid s_tready s_tdata      one circle command item
// m_        out        m_tvalid m_tready m_tdata      one span item per row offset
//                      m_tuser m_tlast                (middle row, last span)
//
// A command is accepted only while the block is idle. Each row offset passes
// through the sequencer states in turn: start starts the square root, wait
// covers the seven root steps and sees the root finish, and load loads the
// output register once the output is free. The shared square root unit
// thus paces the rows.
// A stalled output holds the sequencer in its load state; the root for the
// next row is worked out while the previous span waits, and a new command
// is taken while the last span of the previous one still waits.
// Reset clears the sequencer, the root unit's control and the output valid;
// there is no clearing pass.
//
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // center_x [14:0], center_y [29:15], radius [35:30], red [43:36],
    // green [51:44], blue [59:52], alpha [67:60], zero fill [71:68]
    input  logic [fcsg_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // span_x [15:0], row_above [31:16], row_below [47:32],
    // span_width [54:48], span_red [62:55], span_green [70:63],
    // span_blue [78:71], span_alpha [86:79], zero fill [87]
    output logic [fcsg_pkg::M_TDATA_W-1:0] m_tdata,
    // middle_row [0]
    output logic                           m_tuser,
    // last_span
    output logic                           m_tlast
);
    import fcsg_pkg::*;

    localparam logic [RAD_W-1:0] RAD_LIMIT = MAX_RADIUS[RAD_W-1:0];

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;

    // Held command.
    logic signed [COORD_W-1:0]     cx_reg;
    logic signed [COORD_W-1:0]     cy_reg;
    logic [RAD_W-1:0]              rad_reg;
    logic [COLOR_W-1:0]            color_reg;

    // Row offset and the square root operand r*r - d*d, which is stepped
    // down by 2d + 1 as the offset advances.
    logic [RAD_W-1:0]              d_reg;
    logic [SQ_W-1:0]               n_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [M_TDATA_W-1:0]          m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    logic                          accept;
    logic                          out_free;
    logic                          load_out;
    logic                          last_row;
    logic [RAD_W-1:0]              rad_in;
    logic [RAD_W-1:0]              rad_sat;
    logic [SQ_W-1:0]               rad_sq;

    logic [ROOT_W-1:0]             half_w;
    root_status_t                  root_status;

    logic signed [OUT_COORD_W-1:0] span_x;
    logic signed [OUT_COORD_W-1:0] row_above;
    logic signed [OUT_COORD_W-1:0] row_below;
    logic [WIDTH_W-1:0]            span_width;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_LOAD) && out_free;
    assign last_row = (d_reg == rad_reg);

    // Radius beyond the limit saturates; its square seeds the operand.
    always_comb begin
        rad_in  = s_tdata[35:30];
        rad_sat = (rad_in > RAD_LIMIT) ? RAD_LIMIT : rad_in;
        rad_sq  = SQ_W'(rad_sat) * SQ_W'(rad_sat);
    end

    fcsg_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_START),
        .operand (n_reg),
        .status  (root_status),
        .root    (half_w)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (root_status.done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = last_row ? ST_IDLE : ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command capture and row stepping.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg    <= s_tdata[14:0];
            cy_reg    <= s_tdata[29:15];
            rad_reg   <= rad_sat;
            color_reg <= {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52], s_tdata[67:60]};
            d_reg     <= '0;
            n_reg     <= rad_sq;
        end else if (load_out && !last_row) begin
            d_reg <= d_reg + RAD_W'(1);
            n_reg <= n_reg - {{(SQ_W - RAD_W - 1){1'b0}}, d_reg, 1'b1};
        end
    end

    // Span fields for the current row offset.
    always_comb begin
        span_x     = {cx_reg[COORD_W-1], cx_reg}
                     - {{(OUT_COORD_W - ROOT_W){1'b0}}, half_w};
        row_above  = {cy_reg[COORD_W-1], cy_reg}
                     - {{(OUT_COORD_W - RAD_W){1'b0}}, d_reg};
        row_below  = {cy_reg[COORD_W-1], cy_reg}
                     + {{(OUT_COORD_W - RAD_W){1'b0}}, d_reg};
        span_width = {half_w, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {1'b0,
                            color_reg[7:0], color_reg[15:8],
                            color_reg[23:16], color_reg[31:24],
                            span_width, row_below, row_above, span_x};
            m_tuser_reg <= (d_reg == '0);
            m_tlast_reg <= last_row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The row offset never runs past the held radius while a circle is
    // being drawn.
    a_offset_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (d_reg <= rad_reg))
        else $error("row offset beyond radius");

    // The root unit only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        root_status.done |-> (state_reg == ST_WAIT))
        else $error("square root finished outside wait state");

    // The middle row span covers a single row.
    a_middle_single_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tuser_reg) |-> (m_tdata_reg[31:16] == m_tdata_reg[47:32]))
        else $error("middle row span with distinct rows");

    // An accepted command always starts its first root at once.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_START) && (d_reg == '0))
        else $error("command accepted without starting first row");

endmodule
